>>> rtl/esm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and arithmetic helpers for the Euler/scale transform block.
package esm_pkg;

  // Output fraction bits of the matrix elements.
  localparam int OUT_FRAC_BITS = 16;

  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam int          RAD_STEP  = 292818;      // pi/11520 in Q30
  localparam int          SCALE_NUM = 655360000;   // (100*256)^2

  // Angles in 1/64 degree.
  localparam int TURN_OFFSET  = 46080;
  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int EIGHTH_TURN  = 2880;

  localparam int HORNER_STEPS = 5;
  localparam int ELEMS        = 9;
  localparam int DIV_BITS     = 32;
  localparam int D2_W         = 62 - OUT_FRAC_BITS;
  localparam int NUM_W        = 62;

  localparam int SINCOS_LAT = 4 + 3 * HORNER_STEPS + 2;
  localparam int MATRIX_LAT = 3;
  localparam int SCALE_LAT  = 3 + DIV_BITS + 1;
  localparam int PRE_LAT    = SINCOS_LAT + MATRIX_LAT;
  localparam int TOTAL_LAT  = PRE_LAT + SCALE_LAT;

  typedef logic signed [31:0] trig_t;   // signed Q30
  typedef logic signed [32:0] elem_t;   // rotation element, signed Q30

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_e;

  // Horner divisors and floor(2^32/k) reciprocals.
  function automatic logic [6:0] cos_div(input int j);
    logic [6:0] k;
    case (j)
      0: k = 7'd90;
      1: k = 7'd56;
      2: k = 7'd30;
      3: k = 7'd12;
      default: k = 7'd2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] cos_recip(input int j);
    logic [31:0] r;
    case (j)
      0: r = 32'd47721858;
      1: r = 32'd76695844;
      2: r = 32'd143165576;
      3: r = 32'd357913941;
      default: r = 32'h8000_0000;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] sin_div(input int j);
    logic [6:0] k;
    case (j)
      1: k = 7'd72;
      2: k = 7'd42;
      3: k = 7'd20;
      default: k = 7'd6;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] sin_recip(input int j);
    logic [31:0] r;
    case (j)
      1: r = 32'd59652323;
      2: r = 32'd102261126;
      3: r = 32'd214748364;
      default: r = 32'd715827882;
    endcase
    return r;
  endfunction

  // Q30 product, rounded to nearest, halves away from zero.
  function automatic trig_t mulq(input trig_t a, input trig_t b);
    logic [30:0] ua;
    logic [30:0] ub;
    logic [61:0] p;
    logic [31:0] m;
    ua = a[31] ? 31'(-a) : a[30:0];
    ub = b[31] ? 31'(-b) : b[30:0];
    p  = 62'(ua) * 62'(ub);
    m  = 32'((p + (62'd1 << 29)) >> 30);
    return (a[31] != b[31]) ? trig_t'(-m) : trig_t'(m);
  endfunction

endpackage

>>> rtl/esm_sincos.sv
`timescale 1ns / 1ps
// Pipelined fixed-point sine/cosine lane for one Euler angle.
module esm_sincos
  import esm_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output trig_t              sin_o,
  output trig_t              cos_o
);

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    quad_e       quad;
    logic        fold;
  } carry_t;

  // Stage A: wrap into one turn
  logic [16:0] wrap_sum;
  logic [14:0] ang_d, ang_q;

  assign wrap_sum = 17'(TURN_OFFSET) + {angle_i[15], angle_i};

  always_comb begin
    if (wrap_sum >= 17'(3 * FULL_TURN)) begin
      ang_d = 15'(wrap_sum - 17'(3 * FULL_TURN));
    end else if (wrap_sum >= 17'(2 * FULL_TURN)) begin
      ang_d = 15'(wrap_sum - 17'(2 * FULL_TURN));
    end else if (wrap_sum >= 17'(FULL_TURN)) begin
      ang_d = 15'(wrap_sum - 17'(FULL_TURN));
    end else begin
      ang_d = 15'(wrap_sum);
    end
  end

  // Stage B: quadrant and octant fold
  quad_e       quad_d, quad_q, quad_c_q;
  logic [12:0] rem_full;
  logic        fold_d, fold_q, fold_c_q;
  logic [11:0] oct_d, oct_q;

  always_comb begin
    if (ang_q >= 15'(3 * QUARTER_TURN)) begin
      quad_d   = QUAD_3;
      rem_full = 13'(ang_q - 15'(3 * QUARTER_TURN));
    end else if (ang_q >= 15'(2 * QUARTER_TURN)) begin
      quad_d   = QUAD_2;
      rem_full = 13'(ang_q - 15'(2 * QUARTER_TURN));
    end else if (ang_q >= 15'(QUARTER_TURN)) begin
      quad_d   = QUAD_1;
      rem_full = 13'(ang_q - 15'(QUARTER_TURN));
    end else begin
      quad_d   = QUAD_0;
      rem_full = 13'(ang_q);
    end
    fold_d = rem_full > 13'(EIGHTH_TURN);
    oct_d  = fold_d ? 12'(13'(QUARTER_TURN) - rem_full) : 12'(rem_full);
  end

  // Stage C: radians, stage D: square
  logic [29:0] x_q;
  logic [59:0] sq;
  carry_t      cr_q [0:3*HORNER_STEPS];

  assign sq = 60'(x_q) * 60'(x_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q       <= ang_d;
      quad_q      <= quad_d;
      fold_q      <= fold_d;
      oct_q       <= oct_d;
      x_q         <= 30'(oct_q) * 30'(RAD_STEP);
      quad_c_q    <= quad_q;
      fold_c_q    <= fold_q;
      cr_q[0].x    <= x_q;
      cr_q[0].x2   <= sq[59:30];
      cr_q[0].quad <= quad_c_q;
      cr_q[0].fold <= fold_c_q;
    end
  end

  for (genvar i = 1; i <= 3 * HORNER_STEPS; i++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (en_i) cr_q[i] <= cr_q[i-1];
    end
  end

  // Horner steps: product, reciprocal multiply, correction
  logic [30:0] tc_q [0:HORNER_STEPS-1];
  logic [29:0] pc_q [0:HORNER_STEPS-1];
  logic [29:0] vc_q [0:HORNER_STEPS-1];
  logic [29:0] qc_q [0:HORNER_STEPS-1];

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_cos
    logic [30:0] t_in;
    logic [60:0] prod;
    logic [61:0] rprod;
    logic [36:0] qk;
    logic        fix;

    if (j == 0) begin : g_first
      assign t_in = Q30_ONE;
    end else begin : g_next
      assign t_in = tc_q[j-1];
    end

    assign prod  = 61'(cr_q[3*j].x2) * 61'(t_in);
    assign rprod = 62'(pc_q[j]) * 62'(cos_recip(j));
    assign qk    = 37'(qc_q[j]) * 37'(cos_div(j));
    assign fix   = (37'(vc_q[j]) - qk) >= 37'(cos_div(j));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pc_q[j] <= prod[59:30];
        qc_q[j] <= rprod[61:32];
        vc_q[j] <= pc_q[j];
        tc_q[j] <= Q30_ONE - 31'(qc_q[j] + 30'(fix));
      end
    end
  end

  logic [30:0] ts_q [1:HORNER_STEPS-1];
  logic [29:0] ps_q [1:HORNER_STEPS-1];
  logic [29:0] vs_q [1:HORNER_STEPS-1];
  logic [29:0] qs_q [1:HORNER_STEPS-1];

  for (genvar j = 1; j < HORNER_STEPS; j++) begin : g_sin
    logic [30:0] t_in;
    logic [60:0] prod;
    logic [61:0] rprod;
    logic [36:0] qk;
    logic        fix;

    if (j == 1) begin : g_first
      assign t_in = Q30_ONE;
    end else begin : g_next
      assign t_in = ts_q[j-1];
    end

    assign prod  = 61'(cr_q[3*j].x2) * 61'(t_in);
    assign rprod = 62'(ps_q[j]) * 62'(sin_recip(j));
    assign qk    = 37'(qs_q[j]) * 37'(sin_div(j));
    assign fix   = (37'(vs_q[j]) - qk) >= 37'(sin_div(j));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ps_q[j] <= prod[59:30];
        qs_q[j] <= rprod[61:32];
        vs_q[j] <= ps_q[j];
        ts_q[j] <= Q30_ONE - 31'(qs_q[j] + 30'(fix));
      end
    end
  end

  // Stage E: sine = x * t, stage F: symmetry
  logic [60:0] sprod;
  logic [30:0] sm_q, cm_q;
  quad_e       quad_e_q;
  logic        fold_e_q;
  logic [30:0] s0, c0;
  trig_t       ps0, pc0, sin_d, cos_d, sin_q, cos_q;

  assign sprod = 61'(cr_q[3*HORNER_STEPS].x) * 61'(ts_q[HORNER_STEPS-1]);

  always_comb begin
    s0  = fold_e_q ? cm_q : sm_q;
    c0  = fold_e_q ? sm_q : cm_q;
    ps0 = trig_t'({1'b0, s0});
    pc0 = trig_t'({1'b0, c0});
    case (quad_e_q)
      QUAD_0: begin sin_d = ps0;  cos_d = pc0;  end
      QUAD_1: begin sin_d = pc0;  cos_d = -ps0; end
      QUAD_2: begin sin_d = -ps0; cos_d = -pc0; end
      default: begin sin_d = -pc0; cos_d = ps0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sm_q     <= sprod[60:30];
      cm_q     <= tc_q[HORNER_STEPS-1];
      quad_e_q <= cr_q[3*HORNER_STEPS].quad;
      fold_e_q <= cr_q[3*HORNER_STEPS].fold;
      sin_q    <= sin_d;
      cos_q    <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> rtl/esm_matrix.sv
`timescale 1ns / 1ps
// Merge stage: Z-Y-X rotation matrix from the three lanes' sine and cosine.
module esm_matrix
  import esm_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  trig_t sx_i,
  input  trig_t cx_i,
  input  trig_t sy_i,
  input  trig_t cy_i,
  input  trig_t sz_i,
  input  trig_t cz_i,
  output elem_t m_o [ELEMS]
);

  trig_t czcy_q, szcy_q, czsy_q, szsy_q, cysx_q, cycx_q, szcx_q, czcx_q, szsx_q, czsx_q;
  trig_t sx1_q, cx1_q, sy1_q;
  trig_t czsysx_q, czsycx_q, szsysx_q, szsycx_q;
  trig_t czcy2_q, szcy2_q, szcx2_q, czcx2_q, szsx2_q, czsx2_q, cysx2_q, cycx2_q, sy2_q;
  elem_t m_q [ELEMS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      czcy_q <= mulq(cz_i, cy_i);
      szcy_q <= mulq(sz_i, cy_i);
      czsy_q <= mulq(cz_i, sy_i);
      szsy_q <= mulq(sz_i, sy_i);
      cysx_q <= mulq(cy_i, sx_i);
      cycx_q <= mulq(cy_i, cx_i);
      szcx_q <= mulq(sz_i, cx_i);
      czcx_q <= mulq(cz_i, cx_i);
      szsx_q <= mulq(sz_i, sx_i);
      czsx_q <= mulq(cz_i, sx_i);
      sx1_q  <= sx_i;
      cx1_q  <= cx_i;
      sy1_q  <= sy_i;

      czsysx_q <= mulq(czsy_q, sx1_q);
      czsycx_q <= mulq(czsy_q, cx1_q);
      szsysx_q <= mulq(szsy_q, sx1_q);
      szsycx_q <= mulq(szsy_q, cx1_q);
      czcy2_q  <= czcy_q;
      szcy2_q  <= szcy_q;
      szcx2_q  <= szcx_q;
      czcx2_q  <= czcx_q;
      szsx2_q  <= szsx_q;
      czsx2_q  <= czsx_q;
      cysx2_q  <= cysx_q;
      cycx2_q  <= cycx_q;
      sy2_q    <= sy1_q;

      m_q[0] <= 33'(czcy2_q);
      m_q[1] <= 33'(czsysx_q) - 33'(szcx2_q);
      m_q[2] <= 33'(czsycx_q) + 33'(szsx2_q);
      m_q[3] <= 33'(szcy2_q);
      m_q[4] <= 33'(szsysx_q) + 33'(czcx2_q);
      m_q[5] <= 33'(szsycx_q) - 33'(czsx2_q);
      m_q[6] <= -33'(sy2_q);
      m_q[7] <= 33'(cysx2_q);
      m_q[8] <= 33'(cycx2_q);
    end
  end

  assign m_o = m_q;

endmodule

>>> rtl/esm_scale.sv
`timescale 1ns / 1ps
// Element scaling lane: rounded divide by row and global scale, bit-per-stage, saturated.
module esm_scale
  import esm_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  elem_t       elem_i,
  input  logic [15:0] srow_i,
  input  logic [15:0] gscale_i,
  output logic [31:0] res_o
);

  typedef struct packed {
    logic ovf;
    logic neg;
  } flag_t;

  logic [31:0]      mag_d;
  logic [15:0]      s_nz, g_nz;
  logic [NUM_W-1:0] num1_q, num2_q;
  logic [31:0]      den_q;
  logic             neg1_q, neg2_q;
  logic [D2_W-1:0]  d2;
  logic [D2_W-1:0]  d2a_q;
  logic [NUM_W-DIV_BITS-1:0] hi;

  assign mag_d = elem_i[32] ? 32'(-elem_i) : elem_i[31:0];
  assign s_nz  = (srow_i == 16'd0) ? 16'd1 : srow_i;
  assign g_nz  = (gscale_i == 16'd0) ? 16'd1 : gscale_i;
  assign d2    = D2_W'(den_q) << (30 - OUT_FRAC_BITS);
  assign hi    = num2_q[NUM_W-1:DIV_BITS];

  logic [D2_W-1:0] rem_q [0:DIV_BITS-1];
  logic [31:0]     low_q [0:DIV_BITS-1];
  logic [31:0]     quo_q [0:DIV_BITS];
  logic [D2_W-1:0] d2_q  [0:DIV_BITS-1];
  flag_t           fl_q  [0:DIV_BITS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q    <= NUM_W'(mag_d) * NUM_W'(SCALE_NUM);
      den_q     <= 32'(s_nz) * 32'(g_nz);
      neg1_q    <= elem_i[32];
      num2_q    <= num1_q + NUM_W'(d2 >> 1);
      d2a_q     <= d2;
      neg2_q    <= neg1_q;
      rem_q[0]  <= D2_W'(hi);
      low_q[0]  <= num2_q[DIV_BITS-1:0];
      quo_q[0]  <= '0;
      d2_q[0]   <= d2a_q;
      fl_q[0].ovf <= D2_W'(hi) >= d2a_q;
      fl_q[0].neg <= neg2_q;
    end
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    logic [D2_W:0] rs;
    logic          ge;

    assign rs = {rem_q[i], low_q[i][31]};
    assign ge = rs >= {1'b0, d2_q[i]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[i+1] <= {quo_q[i][30:0], ge};
        fl_q[i+1]  <= fl_q[i];
      end
    end

    if (i < DIV_BITS - 1) begin : g_more
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i+1] <= ge ? D2_W'(rs - {1'b0, d2_q[i]}) : D2_W'(rs);
          low_q[i+1] <= {low_q[i][30:0], 1'b0};
          d2_q[i+1]  <= d2_q[i];
        end
      end
    end
  end

  logic [31:0] res_d, res_q, q_fin;
  flag_t       fl_fin;

  assign q_fin  = quo_q[DIV_BITS];
  assign fl_fin = fl_q[DIV_BITS];

  always_comb begin
    if (!fl_fin.neg) begin
      res_d = (fl_fin.ovf || q_fin[31]) ? 32'h7FFF_FFFF : q_fin;
    end else begin
      res_d = (fl_fin.ovf || q_fin > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q_fin);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/euler_scale_to_transform_matrix.sv
`timescale 1ns / 1ps
// Top level: Euler angles, scales and offsets to a scaled rotation plus translation.
//
// One transform per transfer: three angles (1/64 degree, any 16 bit code, wrapped modulo
// 360 degrees), per-axis and global scales in percent (Q8.8, a zero code is read as code 1),
// and three Q16.16 offsets. Three sine/cosine lanes, one per angle, run side by side; a
// merge stage forms the Z-Y-X rotation matrix, and nine element lanes divide each entry by
// its row scale and the global scale (one quotient bit per stage), round and saturate to
// signed Q16.16. Offsets are delayed alongside and leave as the translation. The block
// takes one transfer every cycle while an output buffer entry is free; a result passes
// the sine/cosine lanes, the merge stage and the scaling lanes with their 32-stage
// divider, and is written into the output buffer before it is offered on m_axis. A
// two-entry output buffer lets input continue while one result waits; the whole pipeline
// holds, and s_axis_tready_o drops, only when both entries are occupied.
module euler_scale_to_transform_matrix
  import esm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // global_scale, scale_x, scale_y, scale_z (16 each), offset_x/y/z (32 each),
  // angle_x, angle_y, angle_z (16 each), from bit 0 up
  input  logic [207:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // row0_col0 .. row2_col2 then trans_x, trans_y, trans_z, 32 bits each, from bit 0 up
  output logic [383:0] m_axis_tdata_o
);

  typedef struct packed {
    logic [15:0] g;
    logic [15:0] sz;
    logic [15:0] sy;
    logic [15:0] sx;
  } scales_t;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } offs_t;

  typedef struct packed {
    logic [2:0][31:0]       trans;
    logic [ELEMS-1:0][31:0] elem;
  } res_t;

  logic pipe_en;

  // Input fields
  scales_t in_scl;
  offs_t   in_off;
  logic signed [15:0] ang_x, ang_y, ang_z;

  assign in_scl.g  = s_axis_tdata_i[15:0];
  assign in_scl.sx = s_axis_tdata_i[31:16];
  assign in_scl.sy = s_axis_tdata_i[47:32];
  assign in_scl.sz = s_axis_tdata_i[63:48];
  assign in_off.x  = s_axis_tdata_i[95:64];
  assign in_off.y  = s_axis_tdata_i[127:96];
  assign in_off.z  = s_axis_tdata_i[159:128];
  assign ang_x     = s_axis_tdata_i[175:160];
  assign ang_y     = s_axis_tdata_i[191:176];
  assign ang_z     = s_axis_tdata_i[207:192];

  // Valid tokens and side data travelling with the item
  logic    vld_q [0:TOTAL_LAT-1];
  scales_t scl_q [0:PRE_LAT-1];
  offs_t   off_q [0:TOTAL_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (pipe_en) begin
      vld_q[0] <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      scl_q[0] <= in_scl;
      off_q[0] <= in_off;
    end
  end

  for (genvar i = 1; i < TOTAL_LAT; i++) begin : g_vld
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (pipe_en) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (pipe_en) off_q[i] <= off_q[i-1];
    end
  end

  for (genvar i = 1; i < PRE_LAT; i++) begin : g_scl
    always_ff @(posedge clk_i) begin
      if (pipe_en) scl_q[i] <= scl_q[i-1];
    end
  end

  // Sine/cosine lanes
  trig_t sx, cx, sy, cy, sz, cz;

  esm_sincos u_lane_x (.clk_i, .en_i(pipe_en), .angle_i(ang_x), .sin_o(sx), .cos_o(cx));
  esm_sincos u_lane_y (.clk_i, .en_i(pipe_en), .angle_i(ang_y), .sin_o(sy), .cos_o(cy));
  esm_sincos u_lane_z (.clk_i, .en_i(pipe_en), .angle_i(ang_z), .sin_o(sz), .cos_o(cz));

  // Merge into the rotation matrix
  elem_t rot [ELEMS];

  esm_matrix u_matrix (
    .clk_i,
    .en_i (pipe_en),
    .sx_i (sx),
    .cx_i (cx),
    .sy_i (sy),
    .cy_i (cy),
    .sz_i (sz),
    .cz_i (cz),
    .m_o  (rot)
  );

  // Element scaling lanes, row scale picked per element
  logic [15:0] srow [3];
  res_t        res_d;

  assign srow[0] = scl_q[PRE_LAT-1].sx;
  assign srow[1] = scl_q[PRE_LAT-1].sy;
  assign srow[2] = scl_q[PRE_LAT-1].sz;

  for (genvar e = 0; e < ELEMS; e++) begin : g_elem
    esm_scale u_scale (
      .clk_i,
      .en_i     (pipe_en),
      .elem_i   (rot[e]),
      .srow_i   (srow[e / 3]),
      .gscale_i (scl_q[PRE_LAT-1].g),
      .res_o    (res_d.elem[e])
    );
  end

  assign res_d.trans[0] = off_q[TOTAL_LAT-1].x;
  assign res_d.trans[1] = off_q[TOTAL_LAT-1].y;
  assign res_d.trans[2] = off_q[TOTAL_LAT-1].z;

  // Two-entry output buffer; pipeline advances while an entry is free
  res_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign pipe_en = (cnt_q != 2'd2);
  assign push    = pipe_en && vld_q[TOTAL_LAT-1];
  assign pop     = m_axis_tvalid_o && m_axis_tready_i;
  assign cnt_d   = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= res_d;
  end

  assign s_axis_tready_o = pipe_en;
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = buf_q[rd_ptr_q];

endmodule

>>> rtl/esm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the transform block, bound to the top level.
module esm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [383:0] m_axis_tdata_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  // Input stalls only when results are queued
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  a_stall_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(m_axis_tvalid_o))
    else $error("buffer filled from empty in one cycle");

  // Ready returns once a stalled result is taken
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready_o && m_axis_tready_i) |=> s_axis_tready_o)
    else $error("input still stalled after a result left");

endmodule

bind euler_scale_to_transform_matrix esm_checker u_esm_checker (.*);
